@@ hdl/nps_pkg.sv @@
// Package: widths, reset value, controller states and control bundles of the prime search.
`timescale 1ns / 1ps
package nps_pkg;

  localparam int NUM_WIDTH = 20;
  localparam int OUT_W     = NUM_WIDTH + 1;
  // trial divisor never passes sqrt(2^OUT_W) + 2
  localparam int D_W       = NUM_WIDTH / 2 + 2;
  localparam int SQ_W      = NUM_WIDTH + 2;
  localparam int CNT_W     = $clog2(OUT_W);

  localparam logic [NUM_WIDTH-1:0] LIMIT_RESET   = NUM_WIDTH'(100000);
  localparam logic [OUT_W-1:0]     SMALLEST_PRIME = OUT_W'(3);
  localparam logic [CNT_W-1:0]     DIV_LAST       = CNT_W'(OUT_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_TEST,
    ST_DIV,
    ST_EVAL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load_cand;
    logic step_cand;
    logic init_d;
    logic next_d;
    logic div_start;
    logic div_step;
    logic load_out;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic cand_le_limit;
    logic cand_small;
    logic dsq_gt_cand;
    logic div_last;
    logic rem_zero;
  } status_t;

endpackage

@@ hdl/nps_if.sv @@
// Interfaces: input word, result word and limit write channels.
`timescale 1ns / 1ps
interface nps_in_if;
  logic                          valid;
  logic                          ready;
  logic [nps_pkg::NUM_WIDTH-1:0] start_value;
  modport source (output valid, output start_value, input ready);
  modport sink   (input valid, input start_value, output ready);
endinterface

interface nps_out_if;
  logic                      valid;
  logic                      ready;
  logic [nps_pkg::OUT_W-1:0] prime_value;
  logic                      found;
  modport source (output valid, output prime_value, output found, input ready);
  modport sink   (input valid, input prime_value, input found, output ready);
endinterface

interface nps_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [nps_pkg::NUM_WIDTH-1:0] upper_limit;
  modport source (output valid, output upper_limit, input ready);
  modport sink   (input valid, input upper_limit, output ready);
endinterface

@@ hdl/nps_dpath.sv @@
// Datapath: candidate, limit register, trial divisor and its square, bit-serial remainder unit.
`timescale 1ns / 1ps
module nps_dpath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nps_pkg::cmd_t                 cmd_i,
  output nps_pkg::status_t              stat_o,
  input  logic [nps_pkg::NUM_WIDTH-1:0] start_value_i,
  input  logic                          cfg_we_i,
  input  logic [nps_pkg::NUM_WIDTH-1:0] cfg_limit_i,
  output logic [nps_pkg::OUT_W-1:0]     prime_value_o,
  output logic                          found_o
);
  import nps_pkg::*;

  logic [NUM_WIDTH-1:0] limit_q;
  logic [OUT_W-1:0]     cand_q, cand_d;
  logic [D_W-1:0]       d_q, d_d;
  logic [SQ_W-1:0]      dsq_q, dsq_d;
  logic [D_W-1:0]       rem_q, rem_d;
  logic [OUT_W-1:0]     quo_q, quo_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [OUT_W-1:0]     prime_q;
  logic                 found_q;
  logic [D_W:0]         trial;
  logic [D_W:0]         trial_sub;
  logic [OUT_W-1:0]     first_cand;

  // hold the limit; reset gives the default
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      limit_q <= cfg_limit_i;
    end
  end

  // first odd number above the input
  assign first_cand = start_value_i[0] ? ({1'b0, start_value_i} + OUT_W'(2))
                                       : ({1'b0, start_value_i} + OUT_W'(1));

  // one restoring division step: shift in the next dividend bit, subtract if it fits
  assign trial     = {rem_q, quo_q[OUT_W-1]};
  assign trial_sub = trial - {1'b0, d_q};

  always_comb begin
    cand_d = cand_q;
    d_d    = d_q;
    dsq_d  = dsq_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    if (cmd_i.load_cand) begin
      cand_d = first_cand;
    end else if (cmd_i.step_cand) begin
      cand_d = cand_q + OUT_W'(2);
    end
    // (d + 2)^2 = d^2 + 4d + 4
    if (cmd_i.init_d) begin
      d_d   = D_W'(3);
      dsq_d = SQ_W'(9);
    end else if (cmd_i.next_d) begin
      d_d   = d_q + D_W'(2);
      dsq_d = dsq_q + SQ_W'({d_q, 2'b00}) + SQ_W'(4);
    end
    if (cmd_i.div_start) begin
      rem_d = '0;
      quo_d = cand_q;
      cnt_d = '0;
    end else if (cmd_i.div_step) begin
      rem_d = trial[D_W] ? trial_sub[D_W-1:0]
            : ((trial >= {1'b0, d_q}) ? trial_sub[D_W-1:0] : trial[D_W-1:0]);
      quo_d = {quo_q[OUT_W-2:0], 1'b0};
      cnt_d = cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    cand_q <= cand_d;
    d_q    <= d_d;
    dsq_q  <= dsq_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    cnt_q  <= cnt_d;
  end

  // capture the result word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      prime_q <= cand_q;
      found_q <= cmd_i.found;
    end
  end

  assign stat_o.cand_le_limit = cand_q <= {1'b0, limit_q};
  assign stat_o.cand_small    = cand_q < SMALLEST_PRIME;
  assign stat_o.dsq_gt_cand   = dsq_q > {1'b0, cand_q};
  assign stat_o.div_last      = cnt_q == DIV_LAST;
  assign stat_o.rem_zero      = rem_q == '0;

  assign prime_value_o = prime_q;
  assign found_o       = found_q;

`ifndef NO_ASSERTIONS
  a_cand_odd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.init_d |-> cand_q[0])
    else $error("even candidate reached the divisor loop");

  a_step_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.step_cand |=> cand_q == $past(cand_q) + OUT_W'(2))
    else $error("candidate did not advance by two");

  a_rem_below_d: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cmd_i.div_step) |-> rem_q < d_q)
    else $error("partial remainder not below divisor");
`endif

endmodule

@@ hdl/nps_ctrl.sv @@
// Controller: sequences candidates, divisor trials and the result word handoff.
`timescale 1ns / 1ps
module nps_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output nps_pkg::cmd_t    cmd_o,
  input  nps_pkg::status_t stat_i
);
  import nps_pkg::*;

  state_e state_q, state_d;
  logic   hit_q, hit_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and datapath commands
  always_comb begin
    state_d    = state_q;
    hit_d      = hit_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_cand = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!stat_i.cand_le_limit) begin
          hit_d   = 1'b0;
          state_d = ST_FINISH;
        end else if (stat_i.cand_small) begin
          cmd_o.step_cand = 1'b1;
        end else begin
          cmd_o.init_d = 1'b1;
          state_d      = ST_TEST;
        end
      end
      ST_TEST: begin
        if (stat_i.dsq_gt_cand) begin
          hit_d   = 1'b1;
          state_d = ST_FINISH;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (stat_i.rem_zero) begin
          cmd_o.step_cand = 1'b1;
          state_d         = ST_CHECK;
        end else begin
          cmd_o.next_d = 1'b1;
          state_d      = ST_TEST;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          cmd_o.found    = hit_q;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // hold the result word until taken
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef NO_ASSERTIONS
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV && !stat_i.div_last) |=> state_q == ST_DIV)
    else $error("division left before its last step");

  a_valid_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FINISH)
    else $error("result word raised outside finish");

  a_prime_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_TEST && stat_i.dsq_gt_cand) |=> hit_q && state_q == ST_FINISH)
    else $error("prime candidate not flagged as found");
`endif

endmodule

@@ hdl/next_prime_search.sv @@
// Search: per candidate, a trial by each odd divisor from 3 up to sqrt(candidate), then the
// result handoff; a prime is accepted once the divisor's square exceeds it, and
// composites stop at their smallest factor.
// Throughput: one word at a time; the bit-serial remainder unit sets the rate. A new
// word is taken while the last result still waits.
// Reset: asynchronous active low; clears control and restores the limit to 100000.
`timescale 1ns / 1ps
module next_prime_search (
  input  logic              clk_i,
  input  logic              rst_ni,
  nps_in_if.sink            start_i,
  nps_out_if.source         result_o,
  nps_cfg_if.sink           cfg_i
);
  import nps_pkg::*;

  cmd_t    cmd;
  status_t stat;

  // limit writes are always taken
  assign cfg_i.ready = 1'b1;

  nps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (start_i.valid),
    .in_ready_o  (start_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  nps_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .start_value_i (start_i.start_value),
    .cfg_we_i      (cfg_i.valid),
    .cfg_limit_i   (cfg_i.upper_limit),
    .prime_value_o (result_o.prime_value),
    .found_o       (result_o.found)
  );

endmodule

@@ bench/tb_top.sv @@
// Testbench for next_prime_search: table-driven and random words checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
  import nps_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;
  localparam int N_DIRECTED  = 23;
  localparam int N_PHASES    = 4;
  localparam int WORDS_PHASE = 25;
  localparam int DRAIN_WAIT  = 100;

  typedef struct packed {
    logic [OUT_W-1:0] prime;
    logic             found;
  } prime_res_t;

  // one directed row: limit to run under, start word, optional typed result
  typedef struct packed {
    logic [NUM_WIDTH-1:0] limit;
    logic [NUM_WIDTH-1:0] start;
    logic                 typed;
    logic [OUT_W-1:0]     prime;
    logic                 found;
  } dir_row_t;

  logic clk;
  logic rst_n;

  nps_in_if  start_bus ();
  nps_out_if result_bus ();
  nps_cfg_if cfg_bus ();

  next_prime_search u_top (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .start_i  (start_bus),
    .result_o (result_bus),
    .cfg_i    (cfg_bus)
  );

  prime_res_t           pending_q [$];
  logic [NUM_WIDTH-1:0] limit_shadow;
  int                   err_cnt;
  int                   cycle_cnt;
  int                   tx_idle_pct;
  int                   rx_stall_pct;
  int                   rx_hold_req;
  bit                   tx_on;

  dir_row_t dir_rows [N_DIRECTED] = '{
    '{LIMIT_RESET, 20'd0,       1'b1, 21'd3,       1'b1},
    '{LIMIT_RESET, 20'd1,       1'b1, 21'd3,       1'b1},
    '{LIMIT_RESET, 20'd2,       1'b1, 21'd3,       1'b1},
    '{LIMIT_RESET, 20'd3,       1'b1, 21'd5,       1'b1},
    '{LIMIT_RESET, 20'd4,       1'b1, 21'd5,       1'b1},
    '{LIMIT_RESET, 20'd7,       1'b1, 21'd11,      1'b1},
    '{LIMIT_RESET, 20'd99990,   1'b0, 21'd0,       1'b0},
    '{LIMIT_RESET, 20'd99999,   1'b1, 21'd100001,  1'b0},
    '{LIMIT_RESET, 20'hFFFFF,   1'b1, 21'd1048577, 1'b0},
    '{LIMIT_RESET, 20'hFFFFE,   1'b1, 21'd1048575, 1'b0},
    '{20'd3,       20'd0,       1'b1, 21'd3,       1'b1},
    '{20'd3,       20'd2,       1'b1, 21'd3,       1'b1},
    '{20'd3,       20'd3,       1'b1, 21'd5,       1'b0},
    '{20'd3,       20'd4,       1'b1, 21'd5,       1'b0},
    '{20'd0,       20'd0,       1'b1, 21'd1,       1'b0},
    '{20'd0,       20'd1,       1'b1, 21'd3,       1'b0},
    '{20'd2,       20'd2,       1'b1, 21'd3,       1'b0},
    '{20'd97,      20'd89,      1'b1, 21'd97,      1'b1},
    '{20'd97,      20'd96,      1'b1, 21'd97,      1'b1},
    '{20'd97,      20'd97,      1'b1, 21'd99,      1'b0},
    '{20'hFFFFF,   20'hFFFFC,   1'b0, 21'd0,       1'b0},
    '{20'hFFFFF,   20'hFFFFD,   1'b1, 21'd1048577, 1'b0},
    '{20'hFFFFF,   20'h80000,   1'b0, 21'd0,       1'b0}
  };

  // Predict the search: next odd candidate above n, step by two up to the limit
  function automatic prime_res_t search_prime(logic [NUM_WIDTH-1:0] n,
                                              logic [NUM_WIDTH-1:0] lim);
    longint unsigned cand;
    longint unsigned div;
    bit              is_prime;
    prime_res_t      res;
    cand = n[0] ? longint'(n) + 2 : longint'(n) + 1;
    res.found = 1'b0;
    while (cand <= longint'(lim) && !res.found) begin
      is_prime = (cand >= 3) && cand[0];
      for (div = 3; is_prime && div * div <= cand; div += 2) begin
        if (cand % div == 0) is_prime = 0;
      end
      if (is_prime) res.found = 1'b1;
      else cand += 2;
    end
    res.prime = cand[OUT_W-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    err_cnt++;
  endtask

  // Compare the word taken at this edge with the oldest expectation
  task automatic check_result();
    prime_res_t want;
    if (pending_q.size() == 0) begin
      $display("%0t: unexpected result word %0d/%0d", $realtime,
               result_bus.prime_value, result_bus.found);
      err_cnt++;
    end else begin
      want = pending_q.pop_front();
      if (result_bus.prime_value !== want.prime)
        report_mismatch("prime_value", result_bus.prime_value, want.prime);
      if (result_bus.found !== want.found)
        report_mismatch("found", result_bus.found, want.found);
    end
  endtask

  // Drop valid once, only if a word was left on the bus
  task automatic hold_input();
    if (tx_on) begin
      start_bus.valid <= 1'b0;
      tx_on = 0;
    end
  endtask

  task automatic wait_drained();
    hold_input();
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // Offer one start word, at times after a random gap, and queue its expectation
  task automatic send_word(input logic [NUM_WIDTH-1:0] n, input bit typed,
                           input prime_res_t typed_res);
    int gap;
    gap = 0;
    if ($urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      hold_input();
      repeat (gap) @(posedge clk);
    end
    start_bus.valid       <= 1'b1;
    start_bus.start_value <= n;
    tx_on = 1;
    do @(posedge clk); while (!start_bus.ready);
    pending_q.push_back(typed ? typed_res : search_prime(n, limit_shadow));
  endtask

  // Write the limit only with the block idle
  task automatic write_limit(input logic [NUM_WIDTH-1:0] lim);
    wait_drained();
    repeat (10) @(posedge clk);
    cfg_bus.valid       <= 1'b1;
    cfg_bus.upper_limit <= lim;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    limit_shadow = lim;
  endtask

  function automatic logic [NUM_WIDTH-1:0] pick_start(logic [NUM_WIDTH-1:0] lim);
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 5) return NUM_WIDTH'($urandom_range(0, 4095));
    if (sel <= 7) return NUM_WIDTH'($urandom_range(0, 65535));
    if (sel == 8) return NUM_WIDTH'($urandom);
    if (lim > 64) return lim - NUM_WIDTH'($urandom_range(0, 64));
    return NUM_WIDTH'($urandom_range(0, lim));
  endfunction

  always #5 clk = ~clk;

  // Receiver: check each taken word, then pick next ready (long hold first)
  initial begin
    int hold_left;
    hold_left = 0;
    result_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid && result_bus.ready) check_result();
      if (rx_hold_req > 0) begin
        hold_left   = rx_hold_req;
        rx_hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Main sequence: reset, directed table, random phases, drain
  initial begin
    logic [NUM_WIDTH-1:0] lim;
    prime_res_t           typed_res;
    clk                   = 1'b0;
    rst_n                 = 1'b0;
    start_bus.valid       = 1'b0;
    start_bus.start_value = '0;
    cfg_bus.valid         = 1'b0;
    cfg_bus.upper_limit   = '0;
    err_cnt               = 0;
    tx_idle_pct           = 0;
    rx_stall_pct          = 0;
    rx_hold_req           = 0;
    tx_on                 = 0;
    limit_shadow          = LIMIT_RESET;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table, rewriting the limit where a row asks for another
    foreach (dir_rows[i]) begin
      if (dir_rows[i].limit != limit_shadow) write_limit(dir_rows[i].limit);
      typed_res.prime = dir_rows[i].prime;
      typed_res.found = dir_rows[i].found;
      send_word(dir_rows[i].start, dir_rows[i].typed, typed_res);
    end

    // Random phases: no idling, sender idle, receiver stalling, both
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin
          lim = 20'hFFFFF;
          tx_idle_pct = 0;  rx_stall_pct = 0;
        end
        1: begin
          lim = NUM_WIDTH'($urandom_range(3, 5000));
          tx_idle_pct = 66; rx_stall_pct = 0;
        end
        2: begin
          lim = LIMIT_RESET;
          tx_idle_pct = 0;  rx_stall_pct = 66;
        end
        default: begin
          lim = NUM_WIDTH'($urandom_range(3, 20'hFFFFF));
          tx_idle_pct = 24; rx_stall_pct = 24;
        end
      endcase
      write_limit(lim);
      // hold the receiver off so the block backs up onto its input
      if (ph == 0) rx_hold_req = 3000;
      for (int i = 0; i < WORDS_PHASE; i++) begin
        // pause the sender until every result is back
        if (ph == 2 && i == WORDS_PHASE / 2) wait_drained();
        send_word(pick_start(limit_shadow), 1'b0, typed_res);
      end
    end

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ next_prime_search.f @@
hdl/nps_pkg.sv
hdl/nps_if.sv
hdl/nps_dpath.sv
hdl/nps_ctrl.sv
hdl/next_prime_search.sv
bench/tb_top.sv
